### rtl/core/assert_macros.svh
// assertion macros for the search result table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked only out of reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### rtl/core/sasrt_pkg.sv
// shared types and constants of the search result table
package sasrt_pkg;

    localparam int WAYS        = 4;
    localparam int MAX_BUCKETS = 1024;
    localparam int BKT_W       = $clog2(MAX_BUCKETS);
    localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNT_W       = 11;
    localparam int KEY_W       = 64;
    localparam int DIGITS      = 8;
    localparam int STEPS       = KEY_W / DIGITS;
    localparam int STEP_W      = $clog2(STEPS);

    localparam logic [1:0] BND_EXACT = 2'd0;
    localparam logic [1:0] BND_LOWER = 2'd1;
    localparam logic [1:0] BND_UPPER = 2'd2;

    typedef enum logic [1:0] {
        OP_PROBE   = 2'd0,
        OP_STORE   = 2'd1,
        OP_ADVANCE = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_EXEC,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        op_t               opcode;
        logic [KEY_W-1:0]  key;
        logic signed [7:0] depth;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
        logic signed [15:0] score;
        logic [1:0]        bound_kind;
        logic [15:0]       move_code;
        logic              has_eval;
        logic signed [15:0] eval_in;
    } item_t;

    typedef struct packed {
        logic              key_hit;
        logic              cutoff;
        logic [15:0]       move_out;
        logic signed [15:0] score_out;
        logic signed [7:0] depth_out;
        logic [1:0]        bound_out;
        logic              eval_valid;
        logic signed [15:0] eval_out;
    } res_t;

    typedef struct packed {
        logic              hasev;
        logic [7:0]        gen;
        logic [1:0]        bound;
        logic signed [7:0] depth;
    } meta_t;

    typedef struct packed {
        logic signed [15:0] eval;
        logic signed [15:0] score;
        logic [15:0]       move;
    } payload_t;

    typedef struct packed {
        meta_t            meta;
        payload_t         payload;
        logic [KEY_W-1:0] key;
    } way_t;

    typedef way_t [WAYS-1:0] row_t;

    typedef struct packed {
        logic capture;
        logic mod_start;
        logic rd;
        logic exec;
        logic clr;
    } cmd_t;

    typedef struct packed {
        logic mod_done;
        logic clr_last;
    } sts_t;

endpackage

### rtl/core/sasrt_mod.sv
// key modulo bucket count, eight key bits per cycle
module sasrt_mod (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [sasrt_pkg::KEY_W-1:0] key,
    input  logic [sasrt_pkg::CNT_W-1:0] n,
    output logic                      done,
    output logic [sasrt_pkg::BKT_W-1:0] rem
);
    import sasrt_pkg::*;

    logic [KEY_W-1:0]  key_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [CNT_W-1:0]  r_reg, r_next;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W:0]    t;

    always_comb begin
        r_next = r_reg;
        t      = '0;
        for (int i = 0; i < DIGITS; i++) begin
            t = {r_next, key_reg[KEY_W-1-i]};
            if (t >= {1'b0, n_reg}) t = t - {1'b0, n_reg};
            r_next = t[CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            key_reg <= key;
            n_reg   <= n;
            r_reg   <= '0;
        end else if (busy_reg) begin
            key_reg <= {key_reg[KEY_W-DIGITS-1:0], {DIGITS{1'b0}}};
            r_reg   <= r_next;
        end
    end

    assign done = done_reg;
    assign rem  = r_reg[BKT_W-1:0];

endmodule

### rtl/core/sasrt_dp.sv
// datapath: bucket memories, way scan, replacement and result register
module sasrt_dp (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  sasrt_pkg::cmd_t           cmd,
    output sasrt_pkg::sts_t           sts,
    input  sasrt_pkg::item_t          item,
    input  logic [sasrt_pkg::CNT_W-1:0] buckets,
    output sasrt_pkg::res_t           res
);
    import sasrt_pkg::*;

    row_t             data_mem  [MAX_BUCKETS];
    logic [WAYS-1:0]  valid_mem [MAX_BUCKETS];

    item_t            in_reg;
    row_t             rd_row_reg;
    logic [WAYS-1:0]  rd_vld_reg;
    logic [7:0]       gen_reg;
    logic [BKT_W-1:0] clr_idx_reg;
    res_t             res_reg;

    logic [CNT_W-1:0] n_eff;
    logic [BKT_W-1:0] rem;
    logic             mod_done;

    logic             hit;
    logic [WAY_W-1:0] hw;
    logic             found;
    logic [WAY_W-1:0] pick;
    logic signed [9:0] best, pr;
    way_t             old_way, new_way, hit_way;
    logic             same, keep;
    logic [1:0]       bound_new;
    row_t             wr_row;
    logic [WAYS-1:0]  wr_vld;
    res_t             res_new;
    logic             cut;
    logic             vld_we;
    logic [BKT_W-1:0] vld_addr;
    logic [WAYS-1:0]  vld_data;

    // out-of-range counts: zero acts as one, large values clamp
    always_comb begin
        if (buckets == '0) n_eff = CNT_W'(1);
        else if (buckets > CNT_W'(MAX_BUCKETS)) n_eff = CNT_W'(MAX_BUCKETS);
        else n_eff = buckets;
    end

    sasrt_mod u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mod_start),
        .key     (item.key),
        .n       (n_eff),
        .done    (mod_done),
        .rem     (rem)
    );

    // probe: first matching valid way
    always_comb begin
        hit = 1'b0;
        hw  = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!hit && rd_vld_reg[w] && rd_row_reg[w].key == in_reg.key) begin
                hit = 1'b1;
                hw  = WAY_W'(w);
            end
        end
    end

    // store: first free or same-key way, else lowest priority
    always_comb begin
        found = 1'b0;
        pick  = '0;
        best  = 10'sd511;
        pr    = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!found) begin
                if (!rd_vld_reg[w] || rd_row_reg[w].key == in_reg.key) begin
                    found = 1'b1;
                    pick  = WAY_W'(w);
                end else begin
                    pr = {{2{rd_row_reg[w].meta.depth[7]}}, rd_row_reg[w].meta.depth}
                        + ((rd_row_reg[w].meta.gen == gen_reg) ? 10'sd8 : 10'sd0)
                        + ((rd_row_reg[w].meta.bound == BND_EXACT) ? 10'sd2 : 10'sd0);
                    if (pr < best) begin
                        best = pr;
                        pick = WAY_W'(w);
                    end
                end
            end
        end
    end

    always_comb begin
        bound_new = (in_reg.bound_kind > BND_UPPER) ? BND_UPPER : in_reg.bound_kind;
        old_way   = rd_row_reg[pick];
        same      = rd_vld_reg[pick] && old_way.key == in_reg.key;
        keep      = same && old_way.meta.depth > in_reg.depth && bound_new != BND_EXACT;
        new_way   = old_way;
        if (keep) begin
            if (in_reg.has_eval && !old_way.meta.hasev) begin
                new_way.payload.eval = in_reg.eval_in;
                new_way.meta.hasev   = 1'b1;
            end
        end else begin
            new_way.key           = in_reg.key;
            new_way.payload.move  = in_reg.move_code;
            new_way.payload.score = in_reg.score;
            new_way.meta.depth    = in_reg.depth;
            new_way.meta.bound    = bound_new;
            new_way.meta.gen      = gen_reg;
            if (!in_reg.has_eval && same && old_way.meta.hasev) begin
                new_way.payload.eval = old_way.payload.eval;
                new_way.meta.hasev   = 1'b1;
            end else begin
                new_way.payload.eval = in_reg.eval_in;
                new_way.meta.hasev   = in_reg.has_eval;
            end
        end
        wr_row       = rd_row_reg;
        wr_row[pick] = new_way;
        wr_vld       = rd_vld_reg;
        wr_vld[pick] = 1'b1;
    end

    always_comb begin
        hit_way = rd_row_reg[hw];
        cut = hit_way.meta.depth >= in_reg.depth &&
              (hit_way.meta.bound == BND_EXACT ||
               (hit_way.meta.bound == BND_LOWER && hit_way.payload.score >= in_reg.beta) ||
               (hit_way.meta.bound == BND_UPPER && hit_way.payload.score <= in_reg.alpha));
        res_new = '0;
        if (in_reg.opcode == OP_PROBE && hit) begin
            res_new.key_hit    = 1'b1;
            res_new.cutoff     = cut;
            res_new.move_out   = hit_way.payload.move;
            res_new.score_out  = hit_way.payload.score;
            res_new.depth_out  = hit_way.meta.depth;
            res_new.bound_out  = hit_way.meta.bound;
            res_new.eval_valid = hit_way.meta.hasev;
            res_new.eval_out   = hit_way.meta.hasev ? hit_way.payload.eval : 16'sd0;
        end
    end

    // valid bits share one write port between clearing and stores
    always_comb begin
        vld_we   = cmd.clr || (cmd.exec && in_reg.opcode == OP_STORE);
        vld_addr = cmd.clr ? clr_idx_reg : rem;
        vld_data = cmd.clr ? '0 : wr_vld;
    end

    always_ff @(posedge aclk) begin
        if (vld_we) valid_mem[vld_addr] <= vld_data;
        if (cmd.exec && in_reg.opcode == OP_STORE) data_mem[rem] <= wr_row;
        if (cmd.rd) begin
            rd_row_reg <= data_mem[rem];
            rd_vld_reg <= valid_mem[rem];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_reg     <= '0;
            clr_idx_reg <= '0;
        end else begin
            if (cmd.clr) begin
                clr_idx_reg <= sts.clr_last ? '0 : clr_idx_reg + 1'b1;
            end
            if (cmd.exec && in_reg.opcode == OP_ADVANCE) gen_reg <= gen_reg + 1'b1;
            if (cmd.exec && in_reg.opcode == OP_CLEAR) gen_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) in_reg <= item;
        if (cmd.exec) res_reg <= res_new;
    end

    assign sts.mod_done = mod_done;
    assign sts.clr_last = (clr_idx_reg == BKT_W'(MAX_BUCKETS - 1));
    assign res          = res_reg;

endmodule

### rtl/core/sasrt_ctrl.sv
// controller state machine and output handshake
module sasrt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic [1:0]        s_op,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  sasrt_pkg::sts_t   sts,
    output sasrt_pkg::cmd_t   cmd
);
    import sasrt_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    op_t    op;

    assign op       = op_t'(s_op);
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (sts.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (op)
                        OP_PROBE, OP_STORE: state_next = ST_MOD;
                        OP_ADVANCE:         state_next = ST_EXEC;
                        OP_CLEAR:           state_next = ST_CLEAR;
                        default:            state_next = ST_EXEC;
                    endcase
                end
            end
            ST_MOD: begin
                if (sts.mod_done) state_next = ST_READ;
            end
            ST_READ: state_next = ST_EXEC;
            ST_EXEC: begin
                if (out_free) state_next = ST_IDLE;
            end
            ST_CLEAR: begin
                if (sts.clr_last) state_next = ST_EXEC;
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_comb begin
        cmd           = '0;
        s_tready      = (state_reg == ST_IDLE);
        cmd.capture   = (state_reg == ST_IDLE) && s_tvalid;
        cmd.mod_start = cmd.capture && (op == OP_PROBE || op == OP_STORE);
        cmd.rd        = (state_reg == ST_READ);
        cmd.exec      = (state_reg == ST_EXEC) && out_free;
        cmd.clr       = (state_reg == ST_INIT) || (state_reg == ST_CLEAR);
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.exec) out_valid_next = 1'b1;
        else if (m_tready) out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

### rtl/core/set_assoc_search_result_table_top.sv
// top level of the bucketed search result table
// a probe or store passes through the modulo unit, a handoff step, one memory read
//   and one update before m_tvalid; advance goes straight to the update; clear runs
//   a clearing pass over all valid bits first; s_tready is high only in idle
// reset: aresetn synchronous active low; afterwards a pass over every bucket clears
//   the valid bits with s_tready low; config writes are taken during the pass
`include "assert_macros.svh"

module set_assoc_search_result_table_top (
    input  logic         aclk,
    input  logic         aresetn,
    // input transaction
    input  logic         s_tvalid,
    output logic         s_tready,
    // key[63:0] depth[71:64] alpha[87:72] beta[103:88] score[119:104]
    // bound_kind[121:120] move_code[137:122] has_eval[138] eval_in[154:139]
    input  logic [159:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]   s_tuser,
    // result transaction
    output logic         m_tvalid,
    input  logic         m_tready,
    // cutoff[0] move_out[16:1] score_out[32:17] depth_out[40:33]
    // bound_out[42:41] eval_valid[43] eval_out[59:44]
    output logic [63:0]  m_tdata,
    // key_hit[0]
    output logic         m_tuser,
    // configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import sasrt_pkg::*;

    localparam logic [2:0] ADDR_BUCKETS = 3'd0;

    logic [CNT_W-1:0] buckets_reg, buckets_next;
    item_t            item;
    res_t             res;
    cmd_t             cmd;
    sts_t             sts;

    // apb: register written on the access cycle
    assign pready = 1'b1;

    always_comb begin
        buckets_next = buckets_reg;
        if (psel && penable && pwrite && pready && paddr == ADDR_BUCKETS) begin
            buckets_next = pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) buckets_reg <= CNT_W'(MAX_BUCKETS);
        else buckets_reg <= buckets_next;
    end

    assign prdata = (paddr == ADDR_BUCKETS) ? {{(32-CNT_W){1'b0}}, buckets_reg} : 32'd0;

    // unpack the input transaction
    always_comb begin
        item.opcode     = op_t'(s_tuser);
        item.key        = s_tdata[63:0];
        item.depth      = s_tdata[71:64];
        item.alpha      = s_tdata[87:72];
        item.beta       = s_tdata[103:88];
        item.score      = s_tdata[119:104];
        item.bound_kind = s_tdata[121:120];
        item.move_code  = s_tdata[137:122];
        item.has_eval   = s_tdata[138];
        item.eval_in    = s_tdata[154:139];
    end

    sasrt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sasrt_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .item    (item),
        .buckets (buckets_reg),
        .res     (res)
    );

    // pack the result transaction
    assign m_tuser = res.key_hit;
    assign m_tdata = {4'd0, res.eval_out, res.eval_valid, res.bound_out, res.depth_out,
                      res.score_out, res.move_out, res.cutoff};

    // a new result only comes out of an update cycle
    `ASSERT_CLK(a_result_from_exec, $rose(m_tvalid) |-> $past(cmd.exec), "result without update")
    // an update never overwrites a result still waiting
    `ASSERT_CLK(a_no_overwrite, cmd.exec |-> (!m_tvalid || m_tready), "pending result lost")
    // the modulo unit starts only on an accepted transaction
    `ASSERT_CLK(a_mod_on_accept, cmd.mod_start |-> (s_tvalid && s_tready), "stray modulo start")
    // the clearing pass never runs while a transaction is taken
    `ASSERT_CLK(a_clr_no_accept, cmd.clr |-> !s_tready, "accept during clearing pass")

endmodule
